// File: hdl/dpr_pkg.sv
// ----------------------------------------------------------------------------
// dpr_pkg: shared definitions for the direction projection removal block
// Operation codes, table geometry and stream field widths.
// ----------------------------------------------------------------------------
package dpr_pkg;

  // Table geometry
  localparam int HIDDEN  = 1024;
  localparam int LAYERS  = 32;
  localparam int DEPTH   = LAYERS * HIDDEN;
  localparam int ADDR_W  = $clog2(DEPTH);

  // Field widths
  localparam int OP_W    = 2;
  localparam int LAYER_W = 5;
  localparam int IDX_W   = 10;
  localparam int DATA_W  = 32;
  localparam int DIR_W   = 16;
  localparam int SCALE_W = 16;
  localparam int ACC_W   = 64;
  localparam int COEF_W  = 48;

  // Stream payload widths, padded to whole bytes
  localparam int IN_TDATA_W  = ((LAYER_W + IDX_W + DATA_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((DATA_W + IDX_W + 7) / 8) * 8;

  // Operation codes
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_ACC   = 2'd1;
  localparam logic [OP_W-1:0] OP_APPLY = 2'd2;

endpackage

// File: hdl/direction_projection_removal.sv
// ----------------------------------------------------------------------------
// direction_projection_removal: removes a scaled projection onto a stored
// per-layer direction from hidden-state rows.
// ----------------------------------------------------------------------------
//
// Channel   | Dir | Transaction
// ----------+-----+-----------------------------------------------------------
// s_axis    | in  | one element: load direction, accumulate dot, or apply
// m_axis    | out | one steered element per apply element
// cfg       | in  | write of the signed Q8.8 scale register
//
// Load writes the table; accumulate reads it, multiplies and adds, and on
// the row's last element also forms the row coefficient; apply reads,
// multiplies, rounds and emits. The single-port direction memory read and
// the 24-bit split multiplier set these steps. Reset clears scale, loaded
// flag, accumulator and coefficient; the direction memory holds no reset
// value and needs no clearing pass. A result held on m_axis does not block
// new input elements; only an apply result waits on a free output register.
// ----------------------------------------------------------------------------
module direction_projection_removal (
  input  logic                              clk,
  input  logic                              rst,
  // s_axis_tdata: layer[4:0], element_index[14:5], data[46:15], zero pad
  input  logic [dpr_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // s_axis_tuser: operation[1:0]
  input  logic [dpr_pkg::OP_W-1:0]          s_axis_tuser,
  input  logic                              s_axis_tlast,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // m_axis_tdata: result_value[31:0], result_index[41:32], zero pad
  output logic [dpr_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic                              m_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic [dpr_pkg::SCALE_W-1:0]       cfg_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready
);
  import dpr_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_READ  = 4'd1;
  localparam logic [3:0] S_ACC   = 4'd2;
  localparam logic [3:0] S_COEF  = 4'd3;
  localparam logic [3:0] S_MUL1  = 4'd4;
  localparam logic [3:0] S_MUL2  = 4'd5;
  localparam logic [3:0] S_ROUND = 4'd6;
  localparam logic [3:0] S_AP2   = 4'd7;
  localparam logic [3:0] S_AP3   = 4'd8;
  localparam logic [3:0] S_EMIT  = 4'd9;

  logic [3:0]                state;
  logic signed [SCALE_W-1:0] scale;
  logic                      loaded;
  logic signed [ACC_W-1:0]   acc;
  logic signed [COEF_W-1:0]  coef;

  // Latched element
  logic [OP_W-1:0]           op_q;
  logic [LAYER_W-1:0]        layer_q;
  logic [IDX_W-1:0]          idx_q;
  logic signed [DATA_W-1:0]  data_q;
  logic                      last_q;
  logic                      ok_q;

  // Datapath registers
  logic signed [DIR_W-1:0]   dir_q;
  logic signed [47:0]        prod_q;
  logic signed [COEF_W-1:0]  d_q;
  logic signed [40:0]        pp_q;
  logic signed [63:0]        wide_q;
  logic signed [50:0]        term_q;

  // Direction memory
  logic [DIR_W-1:0]          dir_mem [DEPTH];
  logic [DIR_W-1:0]          rd_data;
  logic [ADDR_W-1:0]         mem_addr;
  logic                      mem_we;

  // Input field unpack
  logic [OP_W-1:0]           in_op;
  logic [LAYER_W-1:0]        in_layer;
  logic [IDX_W-1:0]          in_idx;
  logic [DATA_W-1:0]         in_data;
  logic                      in_ok;
  logic                      accept;

  assign in_op    = s_axis_tuser;
  assign in_layer = s_axis_tdata[LAYER_W-1:0];
  assign in_idx   = s_axis_tdata[LAYER_W +: IDX_W];
  assign in_data  = s_axis_tdata[LAYER_W+IDX_W +: DATA_W];
  assign in_ok    = (32'(in_layer) < LAYERS) && (32'(in_idx) < HIDDEN);
  assign mem_addr = ADDR_W'(int'(in_layer) * HIDDEN + int'(in_idx));

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign mem_we        = accept && (in_op == OP_LOAD) && in_ok;

  // Read and write the direction table; read data arrives in the next cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      dir_mem[mem_addr] <= in_data[DIR_W-1:0];
    end
    rd_data <= dir_mem[mem_addr];
  end

  // Arithmetic between register stages
  logic signed [DIR_W-1:0]   dir_sel;
  logic signed [47:0]        dot_prod;
  logic signed [40:0]        coef_lo_prod;
  logic signed [ACC_W:0]     acc_sum;
  logic signed [ACC_W-1:0]   acc_next;
  logic signed [49:0]        acc_sh;
  logic signed [COEF_W-1:0]  d_next;
  logic signed [40:0]        scale_lo_prod;
  logic signed [39:0]        scale_hi_prod;
  logic signed [39:0]        coef_hi_prod;
  logic signed [64:0]        round_sum;
  logic signed [56:0]        round_sh;
  logic signed [COEF_W-1:0]  coef_next;
  logic signed [64:0]        term_sum;
  logic signed [51:0]        diff;
  logic signed [DATA_W-1:0]  diff_sat;
  logic                      steer;

  assign dir_sel      = ok_q ? $signed(rd_data) : '0;
  assign dot_prod     = data_q * dir_sel;
  assign coef_lo_prod = $signed({1'b0, coef[23:0]}) * dir_sel;
  assign coef_hi_prod = $signed(coef[47:24]) * dir_q;

  // Saturating accumulate
  assign acc_sum = {acc[ACC_W-1], acc} + {{17{prod_q[47]}}, prod_q};
  always_comb begin
    if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
      acc_next = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_next = acc_sum[ACC_W-1:0];
    end
  end

  // Scale the accumulator to Q.16 and clamp to 48 bits
  assign acc_sh = acc[ACC_W-1:14];
  always_comb begin
    if (&acc_sh[49:47] || ~|acc_sh[49:47]) begin
      d_next = acc_sh[47:0];
    end else begin
      d_next = acc_sh[49] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
    end
  end

  // scale * d in two halves
  assign scale_lo_prod = scale * $signed({1'b0, d_q[23:0]});
  assign scale_hi_prod = scale * $signed(d_q[47:24]);

  // Round half up, shift to Q32.16, clamp to 48 bits
  assign round_sum = {wide_q[63], wide_q} + 65'sd128;
  assign round_sh  = round_sum[64:8];
  always_comb begin
    if (&round_sh[56:47] || ~|round_sh[56:47]) begin
      coef_next = round_sh[47:0];
    end else begin
      coef_next = round_sh[56] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
    end
  end

  // Apply: round the projection term and subtract with saturation
  assign term_sum = {wide_q[63], wide_q} + 65'sd8192;
  assign diff     = {{20{data_q[DATA_W-1]}}, data_q} - {term_q[50], term_q};
  always_comb begin
    if (&diff[51:31] || ~|diff[51:31]) begin
      diff_sat = diff[31:0];
    end else begin
      diff_sat = diff[51] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
    end
  end
  assign steer = (scale != '0) && loaded && (32'(layer_q) < LAYERS);

  // Sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      scale         <= '0;
      loaded        <= 1'b0;
      acc           <= '0;
      coef          <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        scale <= $signed(cfg_data);
      end
      if (m_axis_tvalid && m_axis_tready && state != S_EMIT) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (in_op)
              OP_LOAD: begin
                if (s_axis_tlast) begin
                  loaded <= 1'b1;
                end
              end
              OP_ACC, OP_APPLY: begin
                state <= S_READ;
              end
              default: begin
              end
            endcase
          end
        end
        S_READ: begin
          state <= (op_q == OP_ACC) ? S_ACC : S_AP2;
        end
        S_ACC: begin
          acc   <= acc_next;
          state <= last_q ? S_COEF : S_IDLE;
        end
        S_COEF: begin
          acc   <= '0;
          state <= S_MUL1;
        end
        S_MUL1: begin
          state <= S_MUL2;
        end
        S_MUL2: begin
          state <= S_ROUND;
        end
        S_ROUND: begin
          coef  <= coef_next;
          state <= S_IDLE;
        end
        S_AP2: begin
          state <= S_AP3;
        end
        S_AP3: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          // Hold until the output register is free
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= in_op;
      layer_q <= in_layer;
      idx_q   <= in_idx;
      data_q  <= $signed(in_data);
      last_q  <= s_axis_tlast;
      ok_q    <= in_ok;
    end
    case (state)
      S_READ: begin
        dir_q  <= dir_sel;
        prod_q <= dot_prod;
        pp_q   <= coef_lo_prod;
      end
      S_COEF: begin
        d_q <= d_next;
      end
      S_MUL1: begin
        pp_q <= scale_lo_prod;
      end
      S_MUL2: begin
        wide_q <= {scale_hi_prod, 24'b0} + {{23{pp_q[40]}}, pp_q};
      end
      S_AP2: begin
        wide_q <= {coef_hi_prod, 24'b0} + {{23{pp_q[40]}}, pp_q};
      end
      S_AP3: begin
        term_q <= term_sum[64:14];
      end
      S_EMIT: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          m_axis_tdata <= {{(OUT_TDATA_W-DATA_W-IDX_W){1'b0}}, idx_q,
                           (steer ? diff_sat : data_q)};
          m_axis_tlast <= last_q;
        end
      end
      default: begin
      end
    endcase
  end

  // Accumulate and apply elements always go through a memory read
  assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_ACC || s_axis_tuser == OP_APPLY))
    |=> state == S_READ)
    else $error("accumulate or apply element skipped the table read");

  // A new result appears only from the emit step
  assert property (@(posedge clk) disable iff (rst)
    (!$past(m_axis_tvalid) || $past(m_axis_tready)) && m_axis_tvalid
    |-> $past(state) == S_EMIT)
    else $error("result issued outside the emit step");

  // The accumulator is clear once the coefficient is being formed
  assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL1 || state == S_MUL2 || state == S_ROUND) |-> acc == '0)
    else $error("dot accumulator not cleared at row end");

  // A row end on the accumulate path always updates the coefficient
  assert property (@(posedge clk) disable iff (rst)
    (state == S_ACC && last_q) |=> ##3 state == S_ROUND)
    else $error("row coefficient sequence broken");

endmodule

// File: test/direction_projection_removal_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// direction_projection_removal_tb: self-checking bench for projection removal
// Loads direction vectors, then streams rows as dot-product passes followed by
// apply passes. A scoreboard class tracks the table, accumulator, coefficient
// and scale, and checks every steered element in order. The scale register is
// rewritten between phases while the block is idle, and both stream sides
// idle at random.
// ----------------------------------------------------------------------------
module direction_projection_removal_tb;
  import dpr_pkg::*;

  localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

  // Stream field positions
  localparam int LAYER_LSB = 0;
  localparam int IDX_LSB   = LAYER_W;
  localparam int DATA_LSB  = LAYER_W + IDX_W;
  localparam int RIDX_LSB  = DATA_W;

  localparam int RANDOM_ITEMS   = 550;
  localparam int SETTLE_CYCLES  = 24;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [IDX_W-1:0]  index;
    logic              last;
  } steered_t;

  // Tracks block state and holds the steered elements still to come out
  class steer_scoreboard;
    logic signed [DIR_W-1:0]   dir_mem [DEPTH];
    bit                        table_ready;
    logic signed [ACC_W-1:0]   dot_sum;
    logic signed [COEF_W-1:0]  coef;
    logic signed [SCALE_W-1:0] scale;
    steered_t                  steered_q[$];
    int                        errors;

    function new();
      for (int i = 0; i < DEPTH; i++) dir_mem[i] = '0;
      table_ready = 1'b0;
      dot_sum     = '0;
      coef        = '0;
      scale       = '0;
      errors      = 0;
    endfunction

    function logic signed [71:0] clamp_to(logic signed [71:0] x, int bits);
      logic signed [71:0] hi;
      logic signed [71:0] lo;
      hi = (72'sd1 <<< (bits - 1)) - 72'sd1;
      lo = -hi - 72'sd1;
      if (x > hi) return hi;
      if (x < lo) return lo;
      return x;
    endfunction

    function void set_scale(logic [SCALE_W-1:0] v);
      scale = v;
    endfunction

    function int pending();
      return steered_q.size();
    endfunction

    function void note_element(logic [OP_W-1:0] op, logic [LAYER_W-1:0] layer,
                               logic [IDX_W-1:0] idx, logic signed [DATA_W-1:0] data,
                               logic last);
      logic [ADDR_W-1:0]  pos;
      logic signed [71:0] wdata;
      logic signed [71:0] wdir;
      logic signed [71:0] wacc;
      logic signed [71:0] wsum;
      logic signed [71:0] wdot;
      logic signed [71:0] wscale;
      logic signed [71:0] wcoef;
      logic signed [71:0] wres;
      steered_t           want;
      pos   = {layer, idx};
      wdata = 72'(data);
      wdir  = 72'(dir_mem[pos]);
      case (op)
        OP_LOAD: begin
          dir_mem[pos] = data[DIR_W-1:0];
          if (last) table_ready = 1'b1;
        end
        OP_ACC: begin
          wacc    = 72'(dot_sum);
          wsum    = clamp_to(wacc + wdata * wdir, ACC_W);
          dot_sum = wsum[ACC_W-1:0];
          // Latch the row coefficient and restart the sum
          if (last) begin
            wdot    = clamp_to(wsum >>> 14, COEF_W);
            wscale  = 72'(scale);
            wcoef   = clamp_to((wscale * wdot + 72'sd128) >>> 8, COEF_W);
            coef    = wcoef[COEF_W-1:0];
            dot_sum = '0;
          end
        end
        OP_APPLY: begin
          want.value = data;
          if (scale != 0 && table_ready) begin
            wcoef      = 72'(coef);
            wres       = clamp_to(wdata - ((wcoef * wdir + 72'sd8192) >>> 14), DATA_W);
            want.value = wres[DATA_W-1:0];
          end
          want.index = idx;
          want.last  = last;
          steered_q.push_back(want);
        end
        default: ;
      endcase
    endfunction

    function void check_output(logic [DATA_W-1:0] value, logic [IDX_W-1:0] index,
                               logic last);
      steered_t want;
      if (steered_q.size() == 0) begin
        $display("%0t: unexpected result value=%h index=%0d last=%0b",
                 $time, value, index, last);
        errors++;
        return;
      end
      want = steered_q.pop_front();
      if (value !== want.value) begin
        $display("%0t: result_value mismatch: expected %h, actual %h",
                 $time, want.value, value);
        errors++;
      end
      if (index !== want.index) begin
        $display("%0t: result_index mismatch: expected %0d, actual %0d",
                 $time, want.index, index);
        errors++;
      end
      if (last !== want.last) begin
        $display("%0t: result_last mismatch: expected %0b, actual %0b",
                 $time, want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [OP_W-1:0]        s_axis_tuser;
  logic                   s_axis_tlast;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [SCALE_W-1:0]     cfg_data;
  logic                   cfg_valid;
  logic                   cfg_ready;

  steer_scoreboard sb;
  int  quiet_cycles = 0;
  int  burst_left   = 0;
  int  sent_count   = 0;
  int  stall_count  = 0;
  int  stall_mode   = 0;
  bit  written [LAYERS][HIDDEN];
  int  wr_list [LAYERS][$];
  int  filled_layers[$];

  direction_projection_removal u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_data      (cfg_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Stall the output side on a pattern whose mode is re-drawn at random
  always @(negedge clk) begin
    stall_count++;
    if (stall_count % 96 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= (stall_count % 8) < 2;
      default: m_axis_tready <= (stall_count % 13) >= 9;
    endcase
  end

  // Record every transaction on all channels and watch for a hang
  always @(posedge clk) begin : monitor
    bit moved;
    moved = 1'b0;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        sb.set_scale(cfg_data);
        moved = 1'b1;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_element(s_axis_tuser, s_axis_tdata[LAYER_LSB +: LAYER_W],
                        s_axis_tdata[IDX_LSB +: IDX_W], s_axis_tdata[DATA_LSB +: DATA_W],
                        s_axis_tlast);
        moved = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_output(m_axis_tdata[DATA_W-1:0], m_axis_tdata[RIDX_LSB +: IDX_W],
                        m_axis_tlast);
        moved = 1'b1;
      end
      if (moved) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  function logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
      default: return $urandom();
    endcase
  endfunction

  function logic [DIR_W-1:0] pick_dir();
    case ($urandom_range(0, 5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return $urandom_range(0, 1) ? 16'h4000 : 16'hC000;
      default: return 16'($urandom());
    endcase
  endfunction

  function logic [SCALE_W-1:0] pick_scale();
    int v;
    case ($urandom_range(0, 7))
      0: v = 25600;
      1: v = -25600;
      2: v = 0;
      3: v = 256;
      4: v = -1;
      5: v = 1;
      default: v = $urandom_range(0, 51200) - 25600;
    endcase
    return v[SCALE_W-1:0];
  endfunction

  // Drive one element in bursts with random gaps; return once accepted
  task automatic send_element(logic [OP_W-1:0] op, int layer, int idx,
                              logic [DATA_W-1:0] data, logic last);
    logic [IN_TDATA_W-1:0] word;
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        s_axis_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    word = '0;
    word[LAYER_LSB +: LAYER_W] = LAYER_W'(layer);
    word[IDX_LSB +: IDX_W]     = IDX_W'(idx);
    word[DATA_LSB +: DATA_W]   = data;
    s_axis_tdata  = word;
    s_axis_tuser  = op;
    s_axis_tlast  = last;
    s_axis_tvalid = 1'b1;
    if (op == OP_LOAD && !written[layer][idx]) begin
      written[layer][idx] = 1'b1;
      if (wr_list[layer].size() == 0) filled_layers.push_back(layer);
      wr_list[layer].push_back(idx);
    end
    if (op != OP_RESERVED) sent_count++;
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
  endtask

  // Drop valid and hold off until every steered element is out
  task automatic wait_idle();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_scale(logic [SCALE_W-1:0] v);
    @(negedge clk);
    cfg_data  = v;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic load_run(int layer, int n, bit finish);
    int base;
    bit seq;
    logic [DATA_W-1:0] word;
    base = $urandom_range(0, HIDDEN - 1);
    seq  = 1'($urandom_range(0, 1));
    for (int i = 0; i < n; i++) begin
      word = $urandom();
      word[DIR_W-1:0] = pick_dir();
      send_element(OP_LOAD, layer, seq ? (base + i) % HIDDEN : $urandom_range(0, HIDDEN - 1),
                   word, finish && (i == n - 1));
    end
  endtask

  // Dot-product pass then apply pass over stored elements of one layer
  task automatic project_row(int layer, int n);
    int picks[16];
    logic [DATA_W-1:0] vals[16];
    if (wr_list[layer].size() == 0) return;
    for (int i = 0; i < n; i++) begin
      picks[i] = wr_list[layer][$urandom_range(0, wr_list[layer].size() - 1)];
      vals[i]  = pick_value();
    end
    for (int i = 0; i < n; i++)
      send_element(OP_ACC, layer, picks[i], vals[i], i == n - 1);
    for (int i = 0; i < n; i++)
      send_element(OP_APPLY, layer, picks[i],
                   ($urandom_range(0, 9) < 7) ? vals[i] : pick_value(), i == n - 1);
  endtask

  // Single stray element: reserved op, lone accumulate, lone apply or load
  task automatic noise_item();
    int layer;
    int idx;
    layer = filled_layers[$urandom_range(0, filled_layers.size() - 1)];
    idx   = wr_list[layer][$urandom_range(0, wr_list[layer].size() - 1)];
    case ($urandom_range(0, 3))
      0: send_element(OP_RESERVED, $urandom_range(0, LAYERS - 1),
                      $urandom_range(0, HIDDEN - 1), $urandom(), 1'($urandom_range(0, 1)));
      1: send_element(OP_ACC, layer, idx, pick_value(), 1'($urandom_range(0, 1)));
      2: send_element(OP_APPLY, layer, idx, pick_value(), 1'($urandom_range(0, 1)));
      default: load_run($urandom_range(0, LAYERS - 1), 1, 1'($urandom_range(0, 1)));
    endcase
  endtask

  initial begin
    int stop_at;
    int next_switch;
    int kind;
    int len;
    sb = new();
    rst           = 1'b1;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_LOAD;
    s_axis_tlast  = 1'b0;
    s_axis_tvalid = 1'b0;
    cfg_data      = '0;
    cfg_valid     = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Steering on but table not loaded: values pass through
    write_scale(16'(25600));
    send_element(OP_LOAD, 0, 0, {16'hA5A5, 16'h4000}, 1'b0);
    send_element(OP_LOAD, LAYERS - 1, HIDDEN - 1, {16'hFFFF, 16'h8000}, 1'b0);
    send_element(OP_LOAD, LAYERS - 1, HIDDEN - 2, {16'h0000, 16'h7FFF}, 1'b0);
    send_element(OP_ACC, LAYERS - 1, HIDDEN - 1, 32'h8000_0000, 1'b1);
    send_element(OP_APPLY, LAYERS - 1, HIDDEN - 1, 32'h8000_0000, 1'b1);
    // Reserved op is ignored; a load with last marks the table loaded
    send_element(OP_RESERVED, LAYERS - 1, HIDDEN - 1, 32'hFFFF_FFFF, 1'b1);
    send_element(OP_LOAD, 5, 7, 32'h0000_0001, 1'b1);
    // Large projections that saturate the output both ways
    send_element(OP_ACC, LAYERS - 1, HIDDEN - 2, 32'h7FFF_FFFF, 1'b0);
    send_element(OP_ACC, LAYERS - 1, HIDDEN - 1, 32'h8000_0000, 1'b1);
    send_element(OP_APPLY, LAYERS - 1, HIDDEN - 2, 32'h7FFF_FFFF, 1'b0);
    send_element(OP_APPLY, LAYERS - 1, HIDDEN - 1, 32'h8000_0000, 1'b1);
    send_element(OP_ACC, 0, 0, 32'h7FFF_FFFF, 1'b1);
    send_element(OP_APPLY, 0, 0, 32'h7FFF_FFFF, 1'b1);
    send_element(OP_APPLY, 0, 0, 32'h8000_0000, 1'b1);
    // Zero scale: pass through, accumulate still latches
    wait_idle();
    write_scale('0);
    send_element(OP_APPLY, LAYERS - 1, HIDDEN - 1, 32'h1234_5678, 1'b1);
    send_element(OP_ACC, 0, 0, 32'h0001_0000, 1'b1);
    // Most negative scale used by the bench
    wait_idle();
    write_scale(16'(-25600));
    send_element(OP_APPLY, 0, 0, 32'h8000_0000, 1'b0);
    send_element(OP_APPLY, LAYERS - 1, HIDDEN - 2, 32'h7FFF_FFFF, 1'b1);

    // Random phases, each under its own scale
    stop_at     = sent_count + RANDOM_ITEMS;
    next_switch = sent_count + $urandom_range(50, 90);
    while (sent_count < stop_at) begin
      if (sent_count >= next_switch) begin
        wait_idle();
        write_scale(pick_scale());
        next_switch = sent_count + $urandom_range(50, 90);
      end
      kind = $urandom_range(0, 99);
      if (kind < 65) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 6);
        project_row(filled_layers[$urandom_range(0, filled_layers.size() - 1)], len);
      end else if (kind < 77) begin
        load_run($urandom_range(0, LAYERS - 1), $urandom_range(1, 12),
                 1'($urandom_range(0, 1)));
      end else begin
        noise_item();
      end
    end

    // Drain and settle
    wait_idle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
